FILE: design/assert_macros.svh
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define TMD_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define TMD_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/tmd_pkg.sv
// package: phase, event and error codes, result type and layout functions
`timescale 1ns / 1ps
`default_nettype none

package tmd_pkg;

    typedef logic [3:0] phase_t;

    localparam phase_t PH_KIND     = 4'd0;
    localparam phase_t PH_FLAGS    = 4'd1;
    localparam phase_t PH_ID       = 4'd2;
    localparam phase_t PH_EXTRA    = 4'd3;
    localparam phase_t PH_ROUTELEN = 4'd4;
    localparam phase_t PH_METALEN  = 4'd5;
    localparam phase_t PH_BODYLEN  = 4'd6;
    localparam phase_t PH_NFRAMES  = 4'd7;
    localparam phase_t PH_FRAMELEN = 4'd8;
    localparam phase_t PH_ROUTE    = 4'd9;
    localparam phase_t PH_META     = 4'd10;
    localparam phase_t PH_BODY     = 4'd11;
    localparam phase_t PH_FRAMES   = 4'd12;
    localparam phase_t PH_DONE     = 4'd13;

    localparam logic [2:0] EV_HDR   = 3'd0;
    localparam logic [2:0] EV_ROUTE = 3'd1;
    localparam logic [2:0] EV_META  = 3'd2;
    localparam logic [2:0] EV_BODY  = 3'd3;
    localparam logic [2:0] EV_FBYTE = 3'd4;
    localparam logic [2:0] EV_FEND  = 3'd5;
    localparam logic [2:0] EV_MEND  = 3'd6;
    localparam logic [2:0] EV_ERR   = 3'd7;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_KIND   = 2'd1;
    localparam logic [1:0] ERR_FRAMES = 2'd2;

    localparam logic [7:0] KIND_LAST = 8'd11;

    // flag bits after the flags byte is shifted down by five
    localparam int FLAG_META        = 2;
    localparam int FLAG_HAS_BODY    = 1;
    localparam int FLAG_HAS_NFRAMES = 0;

    typedef struct packed {
        logic [2:0]  ev;
        logic [3:0]  kind;
        logic [3:0]  fid;
        logic [31:0] val;
        logic [5:0]  fnum;
        logic [1:0]  err;
    } res_t;

    typedef struct packed {
        logic valid;
        logic last;
        res_t res;
    } push_t;

    function automatic res_t mk_res(input logic [2:0] ev, input logic [3:0] kind,
                                    input logic [3:0] fid, input logic [31:0] val,
                                    input logic [5:0] fnum, input logic [1:0] err);
        res_t r;
        r.ev   = ev;
        r.kind = kind;
        r.fid  = fid;
        r.val  = val;
        r.fnum = fnum;
        r.err  = err;
        return r;
    endfunction

    // bytes in each header field
    function automatic logic [2:0] field_size(input phase_t ph);
        logic [2:0] s;
        case (ph)
            PH_ID, PH_EXTRA, PH_METALEN, PH_BODYLEN, PH_FRAMELEN: s = 3'd4;
            PH_ROUTELEN, PH_NFRAMES:                             s = 3'd2;
            default:                                             s = 3'd1;
        endcase
        return s;
    endfunction

    // phase that follows ph in the layout of kind k
    function automatic phase_t next_phase(input logic [3:0] k, input phase_t ph);
        phase_t n;
        n = PH_DONE;
        case (ph)
            PH_KIND: begin
                case (k) inside
                    4'd1, 4'd2, [4'd4:4'd11]: n = PH_FLAGS;
                    default:                  n = PH_DONE;
                endcase
            end
            PH_FLAGS: begin
                case (k) inside
                    4'd1, 4'd2:    n = PH_EXTRA;
                    [4'd4:4'd11]:  n = PH_ID;
                    default:       n = PH_DONE;
                endcase
            end
            PH_ID: begin
                case (k) inside
                    4'd4, 4'd6, 4'd9, 4'd10: n = PH_EXTRA;
                    4'd7, 4'd8:              n = PH_ROUTELEN;
                    4'd11:                   n = PH_METALEN;
                    default:                 n = PH_DONE;
                endcase
            end
            PH_EXTRA: begin
                case (k) inside
                    4'd1, 4'd2, 4'd4: n = PH_METALEN;
                    4'd9, 4'd10:      n = PH_ROUTELEN;
                    default:          n = PH_DONE;
                endcase
            end
            PH_ROUTELEN: n = PH_METALEN;
            PH_METALEN: begin
                case (k) inside
                    4'd1, 4'd2, 4'd4: n = PH_BODYLEN;
                    default:          n = PH_NFRAMES;
                endcase
            end
            PH_BODYLEN:  n = PH_META;
            PH_NFRAMES:  n = PH_FRAMELEN;
            PH_FRAMELEN: n = PH_ROUTE;
            PH_ROUTE:    n = PH_META;
            PH_META: begin
                case (k) inside
                    4'd1, 4'd2, 4'd4: n = PH_BODY;
                    default:          n = PH_FRAMES;
                endcase
            end
            default: n = PH_DONE;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: design/tagged_message_deframer_core.sv
// Tagged message deframer core.
// Input channel (s_valid/s_ready/s_data_byte) takes one stream byte per request.
// Result channel (m_valid/m_ready/m_*) gives header events, tagged payload
// bytes, frame-end marks, a message-end mark and errors; m_last flags the final
// result caused by one byte. A byte that completes no field gives no result.
// m_valid is driven from the output register; a byte passes through the input
// queue and the parser before its result reaches that register.
// Payload bytes and partial header bytes sustain one byte a cycle while the result side does not stall.
// After a completed header field the sequencer walks the layout one phase at a time
// (absent sections included), each frame length lookup passes through SQ_SETRD and SQ_SETCK, and
// each result beyond the first of a byte takes a sequencer step of its own; the parser
// sequencer emits at most one result a cycle.
// A four-entry input queue keeps taking bytes while the parser works or the
// result side stalls; when m_ready is low the output register holds its result
// and the parser waits, and the queue fills before s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and the output register
// and returns the parser to waiting for a kind byte; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module tagged_message_deframer_core #(
    parameter int MAX_FRAMES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_event_res,
    output logic [3:0]       m_msg_kind,
    output logic [3:0]       m_field_id,
    output logic [31:0]      m_value,
    output logic [5:0]       m_frame_number,
    output logic [1:0]       m_error_code,
    output logic             m_last
);

    logic            q_valid, q_ready;
    logic [7:0]      q_data;
    logic            out_free;
    tmd_pkg::push_t  push;

    logic            m_valid_reg;
    logic            m_last_reg;
    tmd_pkg::res_t   m_res_reg;

    // front: byte queue
    tmd_infifo u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data_byte),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // back: parser
    tmd_parse #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_data  (q_data),
        .out_free (out_free),
        .push     (push)
    );

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            m_res_reg  <= push.res;
            m_last_reg <= push.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_res    = m_res_reg.ev;
    assign m_msg_kind     = m_res_reg.kind;
    assign m_field_id     = m_res_reg.fid;
    assign m_value        = m_res_reg.val;
    assign m_frame_number = m_res_reg.fnum;
    assign m_error_code   = m_res_reg.err;
    assign m_last         = m_last_reg;

    // checks
    `TMD_ASSERT_IMPLY(a_err_last, aclk, aresetn, m_valid && m_event_res == tmd_pkg::EV_ERR, m_last, "error result not last")
    `TMD_ASSERT_IMPLY(a_mend_last, aclk, aresetn, m_valid && m_event_res == tmd_pkg::EV_MEND, m_last, "message end not last")
    `TMD_ASSERT_IMPLY(a_payload_tags, aclk, aresetn, m_valid && (m_event_res == tmd_pkg::EV_ROUTE || m_event_res == tmd_pkg::EV_META || m_event_res == tmd_pkg::EV_BODY), m_frame_number == 6'd0 && m_field_id == 4'd0 && m_error_code == tmd_pkg::ERR_NONE, "payload tags wrong")
    `TMD_ASSERT_ALWAYS(a_no_overrun, aclk, aresetn, !(push.valid && m_valid_reg && !m_ready), "result overwritten")

endmodule

`default_nettype wire

FILE: design/tmd_infifo.sv
// front: four-entry byte queue between the link and the parser
`timescale 1ns / 1ps
`default_nettype none

module tmd_infifo (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_data
);

    logic [7:0] mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       push, pop;

    // handshake and pointer update
    assign in_ready  = (count_reg != 3'd4);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        count_next  = count_reg + {2'b0, push} - {2'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // byte storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/tmd_parse.sv
// back: message parser sequencer with frame length store and result hold stage
`timescale 1ns / 1ps
`default_nettype none

module tmd_parse #(
    parameter int MAX_FRAMES = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [7:0]   in_data,
    input  wire logic         out_free,
    output tmd_pkg::push_t    push
);

    localparam int IDXW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam logic [31:0] MAXF32 = 32'(MAX_FRAMES);
    localparam logic [5:0]  MAXF6  = 6'(MAX_FRAMES);

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_ENTER, SQ_SETRD, SQ_SETCK, SQ_FEND, SQ_FLUSH
    } sq_t;

    sq_t               sq_reg, sq_next;
    tmd_pkg::phase_t   phase_reg, phase_next;
    tmd_pkg::phase_t   ent_ph_reg, ent_ph_next;
    logic [3:0]        kind_reg, kind_next;
    logic [2:0]        flags_reg, flags_next;
    logic [1:0]        bif_reg, bif_next;
    logic [31:0]       accum_reg, accum_next;
    logic [15:0]       route_left_reg, route_left_next;
    logic [31:0]       meta_left_reg, meta_left_next;
    logic [31:0]       body_left_reg, body_left_next;
    logic [5:0]        ftotal_reg, ftotal_next;
    logic [5:0]        fcursor_reg, fcursor_next;
    logic [31:0]       fleft_reg, fleft_next;
    logic              hold_valid_reg, hold_valid_next;
    tmd_pkg::res_t     hold_reg, hold_next;

    logic [31:0]       store [MAX_FRAMES];
    logic [31:0]       rd_data_reg;

    logic              put, fin, stall, store_we;
    tmd_pkg::res_t     put_res;
    logic [31:0]       acc;
    logic [2:0]        cnt;
    logic              field_done;
    logic              skip;

    // sequencer next state
    always_comb begin
        sq_next         = sq_reg;
        phase_next      = phase_reg;
        ent_ph_next     = ent_ph_reg;
        kind_next       = kind_reg;
        flags_next      = flags_reg;
        bif_next        = bif_reg;
        accum_next      = accum_reg;
        route_left_next = route_left_reg;
        meta_left_next  = meta_left_reg;
        body_left_next  = body_left_reg;
        ftotal_next     = ftotal_reg;
        fcursor_next    = fcursor_reg;
        fleft_next      = fleft_reg;
        put             = 1'b0;
        put_res         = '0;
        fin             = 1'b0;
        store_we        = 1'b0;
        skip            = 1'b0;
        acc             = accum_reg | (32'(in_data) << {bif_reg, 3'b000});
        cnt             = {1'b0, bif_reg} + 3'd1;
        field_done      = (cnt >= tmd_pkg::field_size(phase_reg));

        unique case (sq_reg)
            SQ_IDLE: begin
                if (in_valid) begin
                    case (phase_reg)
                        tmd_pkg::PH_KIND: begin
                            if (in_data == 8'd0 || in_data > tmd_pkg::KIND_LAST) begin
                                kind_next = '0;
                                put       = 1'b1;
                                put_res   = tmd_pkg::mk_res(tmd_pkg::EV_ERR, 4'd0,
                                    tmd_pkg::PH_KIND, 32'(in_data), 6'd0,
                                    tmd_pkg::ERR_KIND);
                                fin       = 1'b1;
                            end else begin
                                flags_next      = '0;
                                bif_next        = '0;
                                accum_next      = '0;
                                route_left_next = '0;
                                meta_left_next  = '0;
                                body_left_next  = '0;
                                ftotal_next     = '0;
                                fcursor_next    = '0;
                                fleft_next      = '0;
                                kind_next       = in_data[3:0];
                                put             = 1'b1;
                                put_res         = tmd_pkg::mk_res(tmd_pkg::EV_HDR,
                                    in_data[3:0], tmd_pkg::PH_KIND, 32'(in_data), 6'd0,
                                    tmd_pkg::ERR_NONE);
                                ent_ph_next     = tmd_pkg::next_phase(in_data[3:0],
                                    tmd_pkg::PH_KIND);
                                sq_next         = SQ_ENTER;
                            end
                        end
                        tmd_pkg::PH_ROUTE: begin
                            put             = 1'b1;
                            put_res         = tmd_pkg::mk_res(tmd_pkg::EV_ROUTE, kind_reg,
                                4'd0, 32'(in_data), 6'd0, tmd_pkg::ERR_NONE);
                            route_left_next = route_left_reg - 16'd1;
                            if (route_left_reg == 16'd1) begin
                                ent_ph_next = tmd_pkg::next_phase(kind_reg, tmd_pkg::PH_ROUTE);
                                sq_next     = SQ_ENTER;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        tmd_pkg::PH_META: begin
                            put            = 1'b1;
                            put_res        = tmd_pkg::mk_res(tmd_pkg::EV_META, kind_reg,
                                4'd0, 32'(in_data), 6'd0, tmd_pkg::ERR_NONE);
                            meta_left_next = meta_left_reg - 32'd1;
                            if (meta_left_reg == 32'd1) begin
                                ent_ph_next = tmd_pkg::next_phase(kind_reg, tmd_pkg::PH_META);
                                sq_next     = SQ_ENTER;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        tmd_pkg::PH_BODY: begin
                            put            = 1'b1;
                            put_res        = tmd_pkg::mk_res(tmd_pkg::EV_BODY, kind_reg,
                                4'd0, 32'(in_data), 6'd0, tmd_pkg::ERR_NONE);
                            body_left_next = body_left_reg - 32'd1;
                            if (body_left_reg == 32'd1) begin
                                ent_ph_next = tmd_pkg::next_phase(kind_reg, tmd_pkg::PH_BODY);
                                sq_next     = SQ_ENTER;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        tmd_pkg::PH_FRAMES: begin
                            put        = 1'b1;
                            put_res    = tmd_pkg::mk_res(tmd_pkg::EV_FBYTE, kind_reg,
                                4'd0, 32'(in_data), fcursor_reg, tmd_pkg::ERR_NONE);
                            fleft_next = fleft_reg - 32'd1;
                            if (fleft_reg == 32'd1) begin
                                sq_next = SQ_FEND;
                            end else begin
                                fin = 1'b1;
                            end
                        end
                        tmd_pkg::PH_FLAGS, tmd_pkg::PH_ID, tmd_pkg::PH_EXTRA,
                        tmd_pkg::PH_ROUTELEN, tmd_pkg::PH_METALEN, tmd_pkg::PH_BODYLEN,
                        tmd_pkg::PH_NFRAMES, tmd_pkg::PH_FRAMELEN: begin
                            if (!field_done) begin
                                accum_next = acc;
                                bif_next   = bif_reg + 2'd1;
                                fin        = 1'b1;
                            end else begin
                                bif_next    = '0;
                                accum_next  = '0;
                                put         = 1'b1;
                                put_res     = tmd_pkg::mk_res(tmd_pkg::EV_HDR, kind_reg,
                                    phase_reg, acc, 6'd0, tmd_pkg::ERR_NONE);
                                ent_ph_next = tmd_pkg::next_phase(kind_reg, phase_reg);
                                sq_next     = SQ_ENTER;
                                case (phase_reg)
                                    tmd_pkg::PH_FLAGS:    flags_next = in_data[7:5];
                                    tmd_pkg::PH_ROUTELEN: route_left_next = acc[15:0];
                                    tmd_pkg::PH_METALEN:  meta_left_next = acc;
                                    tmd_pkg::PH_BODYLEN:  body_left_next = acc;
                                    tmd_pkg::PH_NFRAMES: begin
                                        if (acc > MAXF32) begin
                                            // too many frames: drop the message
                                            put_res         = tmd_pkg::mk_res(
                                                tmd_pkg::EV_ERR, kind_reg,
                                                tmd_pkg::PH_NFRAMES, acc, 6'd0,
                                                tmd_pkg::ERR_FRAMES);
                                            kind_next       = '0;
                                            flags_next      = '0;
                                            route_left_next = '0;
                                            meta_left_next  = '0;
                                            body_left_next  = '0;
                                            ftotal_next     = '0;
                                            fcursor_next    = '0;
                                            fleft_next      = '0;
                                            phase_next      = tmd_pkg::PH_KIND;
                                            sq_next         = SQ_IDLE;
                                            fin             = 1'b1;
                                        end else begin
                                            ftotal_next = acc[5:0];
                                        end
                                    end
                                    tmd_pkg::PH_FRAMELEN: begin
                                        store_we     = (fcursor_reg < MAXF6);
                                        put_res.fnum = fcursor_reg;
                                        fcursor_next = fcursor_reg + 6'd1;
                                        if (fcursor_reg + 6'd1 < ftotal_reg) begin
                                            sq_next = SQ_IDLE;
                                            fin     = 1'b1;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                        default: begin
                            kind_next       = '0;
                            flags_next      = '0;
                            bif_next        = '0;
                            accum_next      = '0;
                            route_left_next = '0;
                            meta_left_next  = '0;
                            body_left_next  = '0;
                            ftotal_next     = '0;
                            fcursor_next    = '0;
                            fleft_next      = '0;
                            phase_next      = tmd_pkg::PH_KIND;
                            fin             = 1'b1;
                        end
                    endcase
                end
            end
            // walk the layout one phase per cycle unless stalled, skipping absent sections
            SQ_ENTER: begin
                if (ent_ph_reg == tmd_pkg::PH_DONE) begin
                    put             = 1'b1;
                    put_res         = tmd_pkg::mk_res(tmd_pkg::EV_MEND, kind_reg, 4'd0,
                        32'd0, 6'd0, tmd_pkg::ERR_NONE);
                    kind_next       = '0;
                    flags_next      = '0;
                    bif_next        = '0;
                    accum_next      = '0;
                    route_left_next = '0;
                    meta_left_next  = '0;
                    body_left_next  = '0;
                    ftotal_next     = '0;
                    fcursor_next    = '0;
                    fleft_next      = '0;
                    phase_next      = tmd_pkg::PH_KIND;
                    sq_next         = SQ_FLUSH;
                end else if (ent_ph_reg == tmd_pkg::PH_FRAMES) begin
                    fcursor_next = '0;
                    sq_next      = SQ_SETRD;
                end else begin
                    case (ent_ph_reg)
                        tmd_pkg::PH_METALEN: skip = !flags_reg[tmd_pkg::FLAG_META];
                        tmd_pkg::PH_BODYLEN: skip = !flags_reg[tmd_pkg::FLAG_HAS_BODY];
                        tmd_pkg::PH_NFRAMES: begin
                            if (!flags_reg[tmd_pkg::FLAG_HAS_BODY]) begin
                                ftotal_next = 6'd0;
                                skip        = 1'b1;
                            end else if (!flags_reg[tmd_pkg::FLAG_HAS_NFRAMES]) begin
                                ftotal_next = 6'd1;
                                skip        = 1'b1;
                            end
                        end
                        tmd_pkg::PH_FRAMELEN: begin
                            fcursor_next = '0;
                            skip         = (ftotal_reg == 6'd0);
                        end
                        tmd_pkg::PH_ROUTE: skip = (route_left_reg == 16'd0);
                        tmd_pkg::PH_META:  skip = (meta_left_reg == 32'd0);
                        tmd_pkg::PH_BODY:  skip = (body_left_reg == 32'd0);
                        default:           skip = 1'b0;
                    endcase
                    if (skip) begin
                        ent_ph_next = tmd_pkg::next_phase(kind_reg, ent_ph_reg);
                    end else begin
                        phase_next = ent_ph_reg;
                        bif_next   = '0;
                        accum_next = '0;
                        fin        = 1'b1;
                        sq_next    = SQ_IDLE;
                    end
                end
            end
            // look up the length of the frame under the cursor
            SQ_SETRD: begin
                if (fcursor_reg < ftotal_reg && fcursor_reg < MAXF6) begin
                    sq_next = SQ_SETCK;
                end else begin
                    ent_ph_next = tmd_pkg::next_phase(kind_reg, tmd_pkg::PH_FRAMES);
                    sq_next     = SQ_ENTER;
                end
            end
            SQ_SETCK: begin
                if (rd_data_reg == 32'd0) begin
                    put          = 1'b1;
                    put_res      = tmd_pkg::mk_res(tmd_pkg::EV_FEND, kind_reg, 4'd0,
                        32'd0, fcursor_reg, tmd_pkg::ERR_NONE);
                    fcursor_next = fcursor_reg + 6'd1;
                    sq_next      = SQ_SETRD;
                end else begin
                    fleft_next = rd_data_reg;
                    phase_next = tmd_pkg::PH_FRAMES;
                    bif_next   = '0;
                    accum_next = '0;
                    fin        = 1'b1;
                    sq_next    = SQ_IDLE;
                end
            end
            SQ_FEND: begin
                put          = 1'b1;
                put_res      = tmd_pkg::mk_res(tmd_pkg::EV_FEND, kind_reg, 4'd0, 32'd0,
                    fcursor_reg, tmd_pkg::ERR_NONE);
                fcursor_next = fcursor_reg + 6'd1;
                sq_next      = SQ_SETRD;
            end
            SQ_FLUSH: begin
                fin     = 1'b1;
                sq_next = SQ_IDLE;
            end
            default: sq_next = SQ_IDLE;
        endcase
    end

    // hold stage: a result not known to be last waits until the next one shows whether it is the last
    always_comb begin
        push            = '0;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (put && fin) begin
            push.valid = 1'b1;
            push.last  = 1'b1;
            push.res   = put_res;
        end else if (put) begin
            push.valid      = hold_valid_reg;
            push.res        = hold_reg;
            hold_valid_next = 1'b1;
            hold_next       = put_res;
        end else if (fin) begin
            push.valid      = hold_valid_reg;
            push.last       = 1'b1;
            push.res        = hold_reg;
            hold_valid_next = 1'b0;
        end
        stall = push.valid && !out_free;
        if (stall) begin
            push.valid = 1'b0;
        end
    end

    assign in_ready = (sq_reg == SQ_IDLE) && !stall;

    // state and registered values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg         <= SQ_IDLE;
            phase_reg      <= tmd_pkg::PH_KIND;
            ent_ph_reg     <= tmd_pkg::PH_KIND;
            kind_reg       <= '0;
            flags_reg      <= '0;
            bif_reg        <= '0;
            accum_reg      <= '0;
            route_left_reg <= '0;
            meta_left_reg  <= '0;
            body_left_reg  <= '0;
            ftotal_reg     <= '0;
            fcursor_reg    <= '0;
            fleft_reg      <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg       <= '0;
        end else if (!stall) begin
            sq_reg         <= sq_next;
            phase_reg      <= phase_next;
            ent_ph_reg     <= ent_ph_next;
            kind_reg       <= kind_next;
            flags_reg      <= flags_next;
            bif_reg        <= bif_next;
            accum_reg      <= accum_next;
            route_left_reg <= route_left_next;
            meta_left_reg  <= meta_left_next;
            body_left_reg  <= body_left_next;
            ftotal_reg     <= ftotal_next;
            fcursor_reg    <= fcursor_next;
            fleft_reg      <= fleft_next;
            hold_valid_reg <= hold_valid_next;
            hold_reg       <= hold_next;
        end
    end

    // frame length store, registered read at the cursor
    always_ff @(posedge aclk) begin
        if (store_we && !stall) begin
            store[fcursor_reg[IDXW-1:0]] <= acc;
        end
        rd_data_reg <= store[fcursor_reg[IDXW-1:0]];
    end

endmodule

`default_nettype wire
